// File: design/mouse_click_qualifier_assert.svh
// ----------------------------------------------------------------------------
// mouse click qualifier assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MOUSE_CLICK_QUALIFIER_ASSERT_SVH
`define MOUSE_CLICK_QUALIFIER_ASSERT_SVH

// condition holds at every clock edge outside reset
`define MCQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MCQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/mcq_pkg.sv
// ----------------------------------------------------------------------------
// mcq_pkg
// Shared widths, codes and types of the mouse click qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mcq_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int TIME_BITS_DEF  = 32;

   localparam int RAW_W      = 16;
   localparam int NOW_W      = 32;
   localparam int CODE_W     = 2;
   localparam int CUR_W      = 12;
   localparam int DLT_W      = 13;
   localparam int FLAG_W     = 4;
   localparam int SIZE_W     = 13;
   localparam int WIN_W      = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CLAMP_W    = 18;
   localparam int NUM_BTN    = 3;

   localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = SIZE_W'(768);
   localparam logic [WIN_W-1:0]  DBL_WINDOW_RST    = WIN_W'(500);

   typedef enum logic [CODE_W-1:0] {
      BTN_IDLE     = 2'd0,
      BTN_PRESS    = 2'd1,
      BTN_HELD     = 2'd2,
      BTN_RELEASED = 2'd3
   } btn_code_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_DBL_WINDOW    = 2'd2,
      CSR_LEFT_HANDED   = 2'd3
   } csr_index_type;

   // per physical button outcome of one item
   typedef struct packed {
      logic press;
      logic idle;
      logic dbl;
   } btn_event_type;

   // bit order matches the result flags: up, double, held, down
   typedef struct packed {
      logic up;
      logic dbl;
      logic held;
      logic down;
   } flags_type;

endpackage

`default_nettype wire

// File: design/mcq_req_if.sv
// ----------------------------------------------------------------------------
// mcq_req_if
// Input channel of the mouse click qualifier: one frame per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcq_req_if
   import mcq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [RAW_W-1:0]  raw_x;
   logic signed [RAW_W-1:0]  raw_y;
   logic [NOW_W-1:0]         now_ms;
   logic [CODE_W-1:0]        left_button;
   logic [CODE_W-1:0]        right_button;
   logic [CODE_W-1:0]        middle_button;
   logic                     window_active;

   modport source (
      output valid, raw_x, raw_y, now_ms, left_button, right_button, middle_button,
             window_active,
      input  ready
   );
   modport sink (
      input  valid, raw_x, raw_y, now_ms, left_button, right_button, middle_button,
             window_active,
      output ready
   );
endinterface

`default_nettype wire

// File: design/mcq_rsp_if.sv
// ----------------------------------------------------------------------------
// mcq_rsp_if
// Result channel of the mouse click qualifier: cursor, deltas and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcq_rsp_if
   import mcq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CUR_W-1:0]         cursor_x;
   logic [CUR_W-1:0]         cursor_y;
   logic signed [DLT_W-1:0]  delta_x;
   logic signed [DLT_W-1:0]  delta_y;
   logic [FLAG_W-1:0]        left_flags;
   logic [FLAG_W-1:0]        right_flags;
   logic [FLAG_W-1:0]        middle_flags;

   modport source (
      output valid, cursor_x, cursor_y, delta_x, delta_y, left_flags, right_flags,
             middle_flags,
      input  ready
   );
   modport sink (
      input  valid, cursor_x, cursor_y, delta_x, delta_y, left_flags, right_flags,
             middle_flags,
      output ready
   );
endinterface

`default_nettype wire

// File: design/mouse_click_qualifier.sv
// Mouse click qualifier: takes one frame per item and returns one result per
// item. Throughput is one item per clock cycle while the result is not stalled.
// An item passes the input register, then the result register, with the
// clamp, delta, press-timing and held-state update done combinationally
// between them. A full input register takes the next item only as its own
// moves on, so a stalled result blocks it. Configuration writes take effect
// on the next item and should be made only while the block is empty.
// ----------------------------------------------------------------------------
// mouse_click_qualifier
// Clamps the cursor, gives deltas and qualifies down, held, double-click and
// up events of three mouse buttons.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mouse_click_qualifier_assert.svh"

module mouse_click_qualifier
   import mcq_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mcq_req_if.sink                    req_ch,
   mcq_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [SIZE_W-1:0] screen_width_ff, screen_width_in;
   logic [SIZE_W-1:0] screen_height_ff, screen_height_in;
   logic [WIN_W-1:0]  dbl_window_ff, dbl_window_in;
   logic              left_handed_ff, left_handed_in;

   // input register
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [RAW_W-1:0] s1_raw_x_ff, s1_raw_y_ff;
   logic [TIME_BITS-1:0]    s1_now_ff;
   logic [CODE_W-1:0]       s1_code_ff [NUM_BTN];
   logic                    s1_active_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CUR_W-1:0]        rsp_cursor_x_ff, rsp_cursor_x_in;
   logic [CUR_W-1:0]        rsp_cursor_y_ff, rsp_cursor_y_in;
   logic [DLT_W-1:0]        rsp_delta_x_ff, rsp_delta_x_in;
   logic [DLT_W-1:0]        rsp_delta_y_ff, rsp_delta_y_in;
   flags_type               rsp_flags_ff [NUM_BTN];
   flags_type               rsp_flags_in [NUM_BTN];

   logic held_ff [NUM_BTN];
   logic held_in [NUM_BTN];

   logic fire;
   logic req_take;

   logic [COORD_BITS-1:0] cur_x, cur_y;
   logic [COORD_BITS:0]   dlt_x, dlt_y;
   logic                  motion;
   btn_event_type         phys_evt [NUM_BTN];
   btn_event_type         log_evt  [NUM_BTN];
   logic [CUR_W+COORD_BITS-1:0]   cur_x_wide, cur_y_wide;
   logic [DLT_W+COORD_BITS:0]     dlt_x_wide, dlt_y_wide;

   // handshake
   assign fire         = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || fire;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ch.ready);

   // configuration writes
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      dbl_window_in    = dbl_window_ff;
      left_handed_in   = left_handed_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata[SIZE_W-1:0];
            CSR_DBL_WINDOW:    dbl_window_in    = csr_wdata[WIN_W-1:0];
            CSR_LEFT_HANDED:   left_handed_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   mcq_cursor #(
      .COORD_BITS (COORD_BITS)
   ) u_cursor (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .raw_x         (s1_raw_x_ff),
      .raw_y         (s1_raw_y_ff),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .cursor_x      (cur_x),
      .cursor_y      (cur_y),
      .delta_x       (dlt_x),
      .delta_y       (dlt_y),
      .motion        (motion)
   );

   for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
      mcq_button #(
         .TIME_BITS (TIME_BITS)
      ) u_button (
         .clock  (clock),
         .reset  (reset),
         .fire   (fire),
         .code   (s1_code_ff[b]),
         .now    (s1_now_ff),
         .window (dbl_window_ff),
         .motion (motion),
         .evt    (phys_evt[b])
      );
   end

   // physical to logical mapping, left and right swap in left-handed mode
   assign log_evt[0] = left_handed_ff ? phys_evt[1] : phys_evt[0];
   assign log_evt[1] = left_handed_ff ? phys_evt[0] : phys_evt[1];
   assign log_evt[2] = phys_evt[2];

   always_comb begin
      for (int l = 0; l < NUM_BTN; l++) begin
         if (log_evt[l].press) begin
            held_in[l] = 1'b1;
         end else if (log_evt[l].idle) begin
            held_in[l] = 1'b0;
         end else begin
            held_in[l] = held_ff[l];
         end
         rsp_flags_in[l].held = held_in[l];
         rsp_flags_in[l].down = s1_active_ff && log_evt[l].press;
         rsp_flags_in[l].dbl  = s1_active_ff && log_evt[l].dbl;
         rsp_flags_in[l].up   = s1_active_ff && log_evt[l].idle && held_ff[l];
         if (!fire) begin
            held_in[l] = held_ff[l];
         end
      end
   end

   // cursor and deltas are zero-extended then cut to the result widths
   always_comb begin
      cur_x_wide      = {{CUR_W{1'b0}}, cur_x};
      cur_y_wide      = {{CUR_W{1'b0}}, cur_y};
      dlt_x_wide      = {{DLT_W{1'b0}}, dlt_x};
      dlt_y_wide      = {{DLT_W{1'b0}}, dlt_y};
      rsp_cursor_x_in = s1_active_ff ? cur_x_wide[CUR_W-1:0] : '0;
      rsp_cursor_y_in = s1_active_ff ? cur_y_wide[CUR_W-1:0] : '0;
      rsp_delta_x_in  = s1_active_ff ? dlt_x_wide[DLT_W-1:0] : '0;
      rsp_delta_y_in  = s1_active_ff ? dlt_y_wide[DLT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         dbl_window_ff    <= DBL_WINDOW_RST;
         left_handed_ff   <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int l = 0; l < NUM_BTN; l++) begin
            held_ff[l] <= 1'b0;
         end
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         dbl_window_ff    <= dbl_window_in;
         left_handed_ff   <= left_handed_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         for (int l = 0; l < NUM_BTN; l++) begin
            held_ff[l] <= held_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_raw_x_ff   <= req_ch.raw_x;
         s1_raw_y_ff   <= req_ch.raw_y;
         s1_now_ff     <= req_ch.now_ms[TIME_BITS-1:0];
         s1_code_ff[0] <= req_ch.left_button;
         s1_code_ff[1] <= req_ch.right_button;
         s1_code_ff[2] <= req_ch.middle_button;
         s1_active_ff  <= req_ch.window_active;
      end
      if (fire) begin
         rsp_cursor_x_ff <= rsp_cursor_x_in;
         rsp_cursor_y_ff <= rsp_cursor_y_in;
         rsp_delta_x_ff  <= rsp_delta_x_in;
         rsp_delta_y_ff  <= rsp_delta_y_in;
         for (int l = 0; l < NUM_BTN; l++) begin
            rsp_flags_ff[l] <= rsp_flags_in[l];
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.cursor_x     = rsp_cursor_x_ff;
   assign rsp_ch.cursor_y     = rsp_cursor_y_ff;
   assign rsp_ch.delta_x      = rsp_delta_x_ff;
   assign rsp_ch.delta_y      = rsp_delta_y_ff;
   assign rsp_ch.left_flags   = rsp_flags_ff[0];
   assign rsp_ch.right_flags  = rsp_flags_ff[1];
   assign rsp_ch.middle_flags = rsp_flags_ff[2];

   `MCQ_ASSERT_NEXT(a_fire_gives_result, fire, rsp_valid_ff, "processed item not presented")
   `MCQ_ASSERT_ALWAYS(a_down_up_exclusive, !rsp_valid_ff || ((!(rsp_flags_ff[0].down && rsp_flags_ff[0].up)) && (!(rsp_flags_ff[1].down && rsp_flags_ff[1].up)) && (!(rsp_flags_ff[2].down && rsp_flags_ff[2].up))), "down and up pulse together")
   `MCQ_ASSERT_ALWAYS(a_double_is_down, !rsp_valid_ff || ((!rsp_flags_ff[0].dbl || rsp_flags_ff[0].down) && (!rsp_flags_ff[1].dbl || rsp_flags_ff[1].down) && (!rsp_flags_ff[2].dbl || rsp_flags_ff[2].down)), "double click without down pulse")
   `MCQ_ASSERT_ALWAYS(a_up_not_held, !rsp_valid_ff || ((!rsp_flags_ff[0].up || !rsp_flags_ff[0].held) && (!rsp_flags_ff[1].up || !rsp_flags_ff[1].held) && (!rsp_flags_ff[2].up || !rsp_flags_ff[2].held)), "up pulse on a held button")

endmodule

`default_nettype wire

// File: design/mcq_cursor.sv
// ----------------------------------------------------------------------------
// mcq_cursor
// Clamps the cursor to the screen and gives motion deltas against the
// previous clamped cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module mcq_cursor
   import mcq_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic signed [RAW_W-1:0] raw_x,
   input  wire logic signed [RAW_W-1:0] raw_y,
   input  wire logic [SIZE_W-1:0]       screen_width,
   input  wire logic [SIZE_W-1:0]       screen_height,
   output logic [COORD_BITS-1:0]        cursor_x,
   output logic [COORD_BITS-1:0]        cursor_y,
   output logic [COORD_BITS:0]          delta_x,
   output logic [COORD_BITS:0]          delta_y,
   output logic                         motion
);

   localparam logic [CLAMP_W-1:0] COORD_TOP = CLAMP_W'((64'd1 << COORD_BITS) - 64'd1);

   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0] prev_y_ff, prev_y_in;

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [RAW_W-1:0] raw,
      input logic [SIZE_W-1:0]       size
   );
      logic [CLAMP_W-1:0] size_top;
      logic [CLAMP_W-1:0] top;
      logic [CLAMP_W-1:0] raw_ext;
      logic [CLAMP_W-1:0] res;
      // zero size behaves as one pixel
      size_top = (size == '0) ? '0 : (CLAMP_W'(size) - CLAMP_W'(1));
      top      = (size_top > COORD_TOP) ? COORD_TOP : size_top;
      raw_ext  = {{(CLAMP_W-RAW_W){raw[RAW_W-1]}}, raw};
      if (raw[RAW_W-1]) begin
         res = '0;
      end else if (raw_ext > top) begin
         res = top;
      end else begin
         res = raw_ext;
      end
      return res[COORD_BITS-1:0];
   endfunction

   always_comb begin
      cursor_x  = clamp_coord(raw_x, screen_width);
      cursor_y  = clamp_coord(raw_y, screen_height);
      delta_x   = {1'b0, cursor_x} - {1'b0, prev_x_ff};
      delta_y   = {1'b0, cursor_y} - {1'b0, prev_y_ff};
      motion    = (cursor_x != prev_x_ff) || (cursor_y != prev_y_ff);
      prev_x_in = fire ? cursor_x : prev_x_ff;
      prev_y_in = fire ? cursor_y : prev_y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mcq_button.sv
// ----------------------------------------------------------------------------
// mcq_button
// Press timing of one physical button: keeps the last press time and the
// armed state and qualifies a press as a double click.
// ----------------------------------------------------------------------------
`default_nettype none

module mcq_button
   import mcq_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic [CODE_W-1:0]    code,
   input  wire logic [TIME_BITS-1:0] now,
   input  wire logic [WIN_W-1:0]     window,
   input  wire logic                 motion,
   output btn_event_type             evt
);

   logic [TIME_BITS-1:0] last_time_ff, last_time_in;
   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] elapsed;
   logic                 armed_now;

   always_comb begin
      // wraps modulo the timestamp width
      elapsed   = now - last_time_ff;
      armed_now = armed_ff && !motion;
      evt.press = (code == BTN_PRESS);
      evt.idle  = (code == BTN_IDLE);
      evt.dbl   = evt.press && armed_now && (elapsed <= TIME_BITS'(window));

      last_time_in = last_time_ff;
      armed_in     = armed_ff;
      if (fire) begin
         armed_in = armed_now;
         if (evt.press) begin
            armed_in     = !evt.dbl;
            last_time_in = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         armed_ff     <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         armed_ff     <= armed_in;
      end
   end

endmodule

`default_nettype wire
